// ===== src/odr_pkg.sv =====
// ----------------------------------------------------------------------------
// odr_pkg: shared definitions for the oscillation detector
// widths of the datapath and the status of the ramp step divider
// ----------------------------------------------------------------------------
package odr_pkg;

  localparam int unsigned TIME_W            = 32;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned GAIN_W            = 31;
  localparam int unsigned HIT_W             = 8;
  localparam int unsigned CFG_IDX_W         = 4;
  localparam int unsigned PROD_W            = TIME_W + GAIN_W;
  localparam int unsigned DIV_W             = TIME_W;
  localparam int unsigned DIV_CNT_W         = $clog2(PROD_W);
  localparam int unsigned REQUIRED_HITS_DEF = 3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/odr_div.sv =====
// ----------------------------------------------------------------------------
// odr_div: restoring divider for the ramp step
// one quotient bit per cycle, quotient held until the next start
// ----------------------------------------------------------------------------
module odr_div
  import odr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output div_stat_t         stat,
  output logic [PROD_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     rem_nxt;
  logic [PROD_W-1:0]    q_r;
  logic [PROD_W-1:0]    q_nxt;
  logic [DIV_W-1:0]     div_r;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;
  logic                 fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_r, q_r[PROD_W-1]};
    trial   = shifted - {1'b0, div_r};
    fits    = (shifted >= {1'b0, div_r});
    rem_nxt = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    q_nxt   = {q_r[PROD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(PROD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

// ===== src/oscillation_detect_damping_ramp.sv =====
// ----------------------------------------------------------------------------
// oscillation_detect_damping_ramp: pedal oscillation detector, gain ramp
// velocity sign flips qualified by half period and swing, hit counting,
// hold after confirmation and a linear damping gain ramp
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_ready  velocity, position, timestamp
//  out_      output     out_valid/out_ready  damping_add, oscillating, hit_count
//  cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one item at a time: in_ready is high only while the sequencer is idle
//  an item takes longest when the ramp steps, set by the 63-step divider
//  that forms floor(elapsed * max_gain / ramp_time); when the gain jumps
//  (first item or ramp_time zero) the divider is skipped, and a disabled
//  item goes straight to the last step
//  the result sits in an output register; the next item is taken while it
//  waits, and the sequencer stalls at its last step only if it is still full
//  rst_n is synchronous, active low; control and config registers get defaults
//  cfg_ready is always high
//
module oscillation_detect_damping_ramp
  import odr_pkg::*;
#(
  parameter int unsigned REQUIRED_HITS = REQUIRED_HITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_velocity,
  input  logic [DATA_W-1:0]    in_position,
  input  logic [TIME_W-1:0]    in_timestamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [GAIN_W-1:0]    out_damping_add,
  output logic                 out_oscillating,
  output logic [HIT_W-1:0]     out_hit_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BAND     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HP   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SW   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP     = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN = CFG_IDX_W'(7);

  // velocity sign codes
  localparam logic [1:0] SGN_NONE = 2'b00;
  localparam logic [1:0] SGN_POS  = 2'b01;
  localparam logic [1:0] SGN_NEG  = 2'b10;

  localparam logic [HIT_W-1:0] REQ_HITS = HIT_W'(REQUIRED_HITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_QUAL,
    S_OSC,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic              enable_r;
  logic [GAIN_W-1:0] band_r;
  logic [TIME_W-1:0] min_hp_r;
  logic [TIME_W-1:0] max_hp_r;
  logic [GAIN_W-1:0] min_swing_r;
  logic [TIME_W-1:0] hold_r;
  logic [TIME_W-1:0] ramp_r;
  logic [GAIN_W-1:0] max_gain_r;

  // detector state
  logic [1:0]        last_sign_r;
  logic              flip_seen_r;
  logic [TIME_W-1:0] last_flip_time_r;
  logic [DATA_W-1:0] last_peak_r;
  logic [HIT_W-1:0]  hits_r;
  logic              confirmed_r;
  logic [TIME_W-1:0] last_confirm_r;
  logic              update_seen_r;
  logic [TIME_W-1:0] last_update_r;
  logic [GAIN_W-1:0] gain_r;

  // per item working registers
  logic [DATA_W-1:0] vel_r;
  logic [DATA_W-1:0] pos_r;
  logic [TIME_W-1:0] ts_r;
  logic [1:0]        sgn_r;
  logic              flip_r;
  logic [TIME_W-1:0] half_r;
  logic [DATA_W:0]   dpos_r;
  logic              osc_r;
  logic [GAIN_W-1:0] target_r;
  logic [TIME_W-1:0] dt_r;
  logic [PROD_W-1:0] prod_r;
  logic [GAIN_W-1:0] diff_r;
  logic              up_r;

  // output register
  logic              out_valid_r;
  logic [GAIN_W-1:0] out_damping_r;
  logic              out_osc_r;
  logic [HIT_W-1:0]  out_hits_r;

  // divider
  logic              div_start;
  div_stat_t         div_stat;
  logic [PROD_W-1:0] div_q;

  // combinational helpers
  logic              accept;
  logic              out_free;
  logic [DATA_W:0]   vel_ext;
  logic [DATA_W:0]   neg_band;
  logic [1:0]        sgn_c;
  logic              flip_c;
  logic [DATA_W:0]   swing_c;
  logic              qual_c;
  logic [HIT_W-1:0]  hits_inc;
  logic              osc_c;
  logic              jump_c;
  logic              step_ge;
  logic [GAIN_W-1:0] ramp_gain;
  logic [TIME_W-1:0] since_confirm;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // sign with dead band: above band is positive, below minus band negative
  always_comb begin
    vel_ext  = {vel_r[DATA_W-1], vel_r};
    neg_band = (DATA_W+1)'(0) - {2'b00, band_r};
    if ($signed(vel_ext) > $signed({2'b00, band_r})) begin
      sgn_c = SGN_POS;
    end else if ($signed(vel_ext) < $signed(neg_band)) begin
      sgn_c = SGN_NEG;
    end else begin
      sgn_c = SGN_NONE;
    end
    flip_c = (sgn_c != SGN_NONE) && (last_sign_r != SGN_NONE) && (sgn_c != last_sign_r);
  end

  // flip qualification: half period window and swing, exact in 33 bits
  always_comb begin
    swing_c  = dpos_r[DATA_W] ? ((DATA_W+1)'(0) - dpos_r) : dpos_r;
    qual_c   = (half_r >= min_hp_r) && (half_r <= max_hp_r) &&
               (swing_c >= {2'b00, min_swing_r});
    hits_inc = (hits_r < REQ_HITS) ? hits_r + 1'b1 : hits_r;
  end

  // hold window after the last confirmation
  assign since_confirm = ts_r - last_confirm_r;
  assign osc_c         = confirmed_r && (since_confirm <= hold_r);

  // first update or zero ramp time jumps straight to the target
  assign jump_c    = !update_seen_r || (ramp_r == '0);
  assign div_start = (state_r == S_MUL) && !jump_c;

  // step never carries the gain past the target
  always_comb begin
    step_ge = (|div_q[PROD_W-1:GAIN_W]) || (div_q[GAIN_W-1:0] >= diff_r);
    if (step_ge) begin
      ramp_gain = target_r;
    end else if (up_r) begin
      ramp_gain = gain_r + div_q[GAIN_W-1:0];
    end else begin
      ramp_gain = gain_r - div_q[GAIN_W-1:0];
    end
  end

  odr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (ramp_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // sequencer, configuration, detector state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      enable_r         <= 1'b0;
      band_r           <= GAIN_W'(65536);
      min_hp_r         <= TIME_W'(2000);
      max_hp_r         <= TIME_W'(50000);
      min_swing_r      <= GAIN_W'(32768);
      hold_r           <= TIME_W'(200000);
      ramp_r           <= TIME_W'(50000);
      max_gain_r       <= GAIN_W'(65536);
      last_sign_r      <= SGN_NONE;
      flip_seen_r      <= 1'b0;
      last_flip_time_r <= '0;
      last_peak_r      <= '0;
      hits_r           <= '0;
      confirmed_r      <= 1'b0;
      last_confirm_r   <= '0;
      update_seen_r    <= 1'b0;
      last_update_r    <= '0;
      gain_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ENABLE:   enable_r    <= cfg_data[0];
          CFG_BAND:     band_r      <= cfg_data[GAIN_W-1:0];
          CFG_MIN_HP:   min_hp_r    <= cfg_data;
          CFG_MAX_HP:   max_hp_r    <= cfg_data;
          CFG_MIN_SW:   min_swing_r <= cfg_data[GAIN_W-1:0];
          CFG_HOLD:     hold_r      <= cfg_data;
          CFG_RAMP:     ramp_r      <= cfg_data;
          CFG_MAX_GAIN: max_gain_r  <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      // result register: filled at the last step, emptied when taken
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= enable_r ? S_SIGN : S_FIN;
          end
        end
        S_SIGN: begin
          state_r <= S_QUAL;
        end
        S_QUAL: begin
          if (flip_r) begin
            if (flip_seen_r) begin
              if (qual_c) begin
                hits_r <= hits_inc;
                if (hits_inc >= REQ_HITS) begin
                  confirmed_r    <= 1'b1;
                  last_confirm_r <= ts_r;
                end
              end else begin
                hits_r <= '0;
              end
            end
            last_peak_r      <= pos_r;
            last_flip_time_r <= ts_r;
            flip_seen_r      <= 1'b1;
          end
          if (sgn_r != SGN_NONE) begin
            last_sign_r <= sgn_r;
          end
          state_r <= S_OSC;
        end
        S_OSC: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (jump_c) begin
            gain_r  <= target_r;
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            gain_r  <= ramp_gain;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (enable_r) begin
              update_seen_r <= 1'b1;
              last_update_r <= ts_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item datapath and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      vel_r <= in_velocity;
      pos_r <= in_position;
      ts_r  <= in_timestamp;
    end
    if (state_r == S_SIGN) begin
      sgn_r  <= sgn_c;
      flip_r <= flip_c;
      half_r <= ts_r - last_flip_time_r;
      dpos_r <= {pos_r[DATA_W-1], pos_r} - {last_peak_r[DATA_W-1], last_peak_r};
      dt_r   <= ts_r - last_update_r;
    end
    // product is ready before the divider starts
    if (state_r == S_OSC) begin
      osc_r    <= osc_c;
      target_r <= osc_c ? max_gain_r : '0;
      prod_r   <= PROD_W'(dt_r) * PROD_W'(max_gain_r);
    end
    if (state_r == S_MUL) begin
      up_r   <= (target_r > gain_r);
      diff_r <= (target_r > gain_r) ? target_r - gain_r : gain_r - target_r;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_damping_r <= enable_r ? gain_r : '0;
      out_osc_r     <= enable_r && osc_r;
      out_hits_r    <= enable_r ? hits_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_damping_add = out_damping_r;
  assign out_oscillating = out_osc_r;
  assign out_hit_count   = out_hits_r;

endmodule

// ===== src/odr_chk.sv =====
// ----------------------------------------------------------------------------
// odr_chk: port level checks for the oscillation detector
// watches the handshakes and result bounds, bound to the top level
// ----------------------------------------------------------------------------
module odr_chk
  import odr_pkg::*;
#(
  parameter int unsigned REQUIRED_HITS = REQUIRED_HITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [GAIN_W-1:0]    out_damping_add,
  input logic                 out_oscillating,
  input logic [HIT_W-1:0]     out_hit_count,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);

  localparam logic [HIT_W-1:0] REQ_HITS = HIT_W'(REQUIRED_HITS);

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an item was accepted");

  // hit count saturates at the required number
  a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_count <= REQ_HITS))
    else $error("hit count above the required number");

  // a waiting result is not dropped
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_damping_add) &&
                                   $stable(out_oscillating) &&
                                   $stable(out_hit_count)))
    else $error("stalled result changed or vanished");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("cfg_ready low");

endmodule

bind oscillation_detect_damping_ramp odr_chk #(.REQUIRED_HITS(REQUIRED_HITS)) u_odr_chk (.*);
